// ----- src/plmvl_pkg.sv -----
// Shared types and constants for the piecewise-linear face reconstruction block
`timescale 1ns / 1ps
package plmvl_pkg;

  localparam int IN_BITS  = 32;
  localparam int POS_BITS = 31;
  localparam int OUT_BITS = 32;
  localparam int THR_BITS = 16;

  // Shared unit operation codes
  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

endpackage

// ----- src/plm_van_leer_face_reconstruct.sv -----
// Top level of the piecewise-linear face reconstruction block
`timescale 1ns / 1ps
// Channel  Handshake               Payload
// in       in_valid / in_ready     line_start, cell_value, center_spacing, half_left, half_right
// out      out_valid / out_ready   left_state, right_state
// cfg      cfg_we                  cfg_data (tiny_threshold)
// A face job in the back is dominated by nine divisions on a radix-2 divider at one quotient bit per cycle;
// a zero dividend or divisor cuts a division short.
// Cells before the fourth of a line are always taken; they issue no face job.
// rst is synchronous; it empties the queue and the window and sets tiny_threshold to 1.
// Up to two face jobs wait in the queue; a face cell stalls on a full queue or a held result.
module plm_van_leer_face_reconstruct #(
  parameter int VALUE_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic line_start,
  input  logic signed [plmvl_pkg::IN_BITS-1:0] cell_value,
  input  logic [plmvl_pkg::POS_BITS-1:0] center_spacing,
  input  logic [plmvl_pkg::POS_BITS-1:0] half_left,
  input  logic [plmvl_pkg::POS_BITS-1:0] half_right,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [plmvl_pkg::OUT_BITS-1:0] left_state,
  output logic signed [plmvl_pkg::OUT_BITS-1:0] right_state,
  input  logic cfg_we,
  input  logic [plmvl_pkg::THR_BITS-1:0] cfg_data
);
  import plmvl_pkg::*;

  localparam int W = VALUE_BITS;
  localparam int NREG = 32;
  localparam int DIVN = W + FRAC_BITS;

  typedef logic signed [W-1:0] val_t;

  // ---------------- front: window and job issue ----------------
  logic job_valid, job_ready;
  logic [11*W-1:0] job_data;
  logic [THR_BITS-1:0] tiny;

  plmvl_front #(
    .VALUE_BITS(W)
  ) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .line_start(line_start), .cell_value(cell_value),
    .center_spacing(center_spacing), .half_left(half_left), .half_right(half_right),
    .job_valid(job_valid), .job_ready(job_ready), .job_data(job_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tiny <= THR_BITS'(1);
    end else if (cfg_we) begin
      tiny <= cfg_data;
    end
  end

  typedef struct packed {
    val_t q_new, q0, q1, q2, s0, s1, s2, l0, l1, r0, r1;
  } job_t;

  job_t job_q [2];
  logic [1:0] job_cnt;
  logic job_wr, job_rd;
  logic job_head;

  assign job_ready = (job_cnt != 2'd2);
  assign job_wr    = job_valid && job_ready;

  // Two-entry queue between front and back
  always_ff @(posedge clk) begin
    if (rst) begin
      job_cnt <= '0;
      job_head <= 1'b0;
    end else begin
      job_cnt <= job_cnt + {1'b0, job_wr} - {1'b0, job_rd};
      if (job_rd) job_head <= ~job_head;
    end
  end

  always_ff @(posedge clk) begin
    if (job_wr) begin
      job_q[job_head ^ job_cnt[0]] <= job_t'(job_data);
    end
  end

  // ---------------- back: sequencer over one shared ALU ----------------
  // Register file of intermediates, indexed by 5-bit slot
  val_t rf [NREG];

  typedef enum logic [2:0] {
    B_IDLE, B_LOAD, B_ISSUE, B_MUL, B_DIV, B_WB, B_OUT
  } bstate_t;
  bstate_t bst;

  typedef struct packed {
    alu_op_t    op;
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] d;
  } uop_t;

  // Slots
  localparam logic [4:0] R_QN = 5'd0, R_Q0 = 5'd1, R_Q1 = 5'd2, R_Q2 = 5'd3,
    R_S0 = 5'd4, R_S1 = 5'd5, R_S2 = 5'd6, R_L0 = 5'd7, R_L1 = 5'd8, R_R0 = 5'd9,
    R_R1 = 5'd10, R_TWO = 5'd11, R_DQL = 5'd12, R_DQC = 5'd13, R_DQR = 5'd14,
    R_CFL = 5'd15, R_CBL = 5'd16, R_CFR = 5'd17, R_CBR = 5'd18, R_T0 = 5'd19,
    R_T1 = 5'd20, R_T2 = 5'd21, R_T3 = 5'd22, R_DQ2 = 5'd23, R_NUM = 5'd24,
    R_CL = 5'd25, R_CR = 5'd26, R_OL = 5'd27, R_OR = 5'd28;

  localparam int NUOP = 50;
  localparam int PCW = $clog2(NUOP + 1);

  // Face program: slopes, ratios, the left and right limiter corrections, then the two face states
  function automatic uop_t prog(input logic [PCW-1:0] pc);
    uop_t u;
    begin
      u = '{OP_ADD, R_T0, R_T0, R_T0};
      unique case (pc)
        PCW'(0):  u = '{OP_SUB, R_Q1, R_Q2, R_T0};
        PCW'(1):  u = '{OP_DIV, R_T0, R_S2, R_DQL};
        PCW'(2):  u = '{OP_SUB, R_Q0, R_Q1, R_T0};
        PCW'(3):  u = '{OP_DIV, R_T0, R_S1, R_DQC};
        PCW'(4):  u = '{OP_SUB, R_QN, R_Q0, R_T0};
        PCW'(5):  u = '{OP_DIV, R_T0, R_S0, R_DQR};
        PCW'(6):  u = '{OP_DIV, R_S1, R_R1, R_CFL};
        PCW'(7):  u = '{OP_DIV, R_S2, R_L1, R_CBL};
        PCW'(8):  u = '{OP_DIV, R_S0, R_R0, R_CFR};
        PCW'(9):  u = '{OP_DIV, R_S1, R_L0, R_CBR};
        // left: h=R1, s1=DQL, s2=DQC
        PCW'(10): u = '{OP_MUL, R_DQL, R_DQC, R_DQ2};
        PCW'(11): u = '{OP_MUL, R_R1, R_DQ2, R_T0};
        PCW'(12): u = '{OP_MUL, R_CFL, R_DQL, R_T1};
        PCW'(13): u = '{OP_MUL, R_CBL, R_DQC, R_T2};
        PCW'(14): u = '{OP_ADD, R_T1, R_T2, R_T1};
        PCW'(15): u = '{OP_MUL, R_T0, R_T1, R_NUM};
        PCW'(16): u = '{OP_MUL, R_DQL, R_DQL, R_T0};
        PCW'(17): u = '{OP_ADD, R_CFL, R_CBL, R_T1};
        PCW'(18): u = '{OP_SUB, R_T1, R_TWO, R_T1};
        PCW'(19): u = '{OP_MUL, R_T1, R_DQ2, R_T1};
        PCW'(20): u = '{OP_ADD, R_T0, R_T1, R_T0};
        PCW'(21): u = '{OP_MUL, R_DQC, R_DQC, R_T1};
        PCW'(22): u = '{OP_ADD, R_T0, R_T1, R_T0};
        PCW'(23): u = '{OP_DIV, R_NUM, R_T0, R_CL};
        // right: h=L0, s1=DQC, s2=DQR
        PCW'(24): u = '{OP_MUL, R_DQC, R_DQR, R_T3};
        PCW'(25): u = '{OP_MUL, R_L0, R_T3, R_T0};
        PCW'(26): u = '{OP_MUL, R_CFR, R_DQC, R_T1};
        PCW'(27): u = '{OP_MUL, R_CBR, R_DQR, R_T2};
        PCW'(28): u = '{OP_ADD, R_T1, R_T2, R_T1};
        PCW'(29): u = '{OP_MUL, R_T0, R_T1, R_NUM};
        PCW'(30): u = '{OP_MUL, R_DQC, R_DQC, R_T0};
        PCW'(31): u = '{OP_ADD, R_CFR, R_CBR, R_T1};
        PCW'(32): u = '{OP_SUB, R_T1, R_TWO, R_T1};
        PCW'(33): u = '{OP_MUL, R_T1, R_T3, R_T1};
        PCW'(34): u = '{OP_ADD, R_T0, R_T1, R_T0};
        PCW'(35): u = '{OP_MUL, R_DQR, R_DQR, R_T1};
        PCW'(36): u = '{OP_ADD, R_T0, R_T1, R_T0};
        PCW'(37): u = '{OP_DIV, R_NUM, R_T0, R_CR};
        PCW'(38): u = '{OP_ADD, R_Q1, R_CL, R_OL};
        PCW'(39): u = '{OP_SUB, R_Q0, R_CR, R_OR};
        default:  u = '{OP_ADD, R_T0, R_T0, R_T0};
      endcase
      prog = u;
    end
  endfunction

  localparam logic [PCW-1:0] PC_LAST = PCW'(39);

  logic [PCW-1:0] pc;
  uop_t uop;
  assign uop = prog(pc);

  val_t opa, opb, res;
  logic [2*W-1:0] prod;
  logic pneg;

  // Saturating pack from magnitude with separate overflow flag
  function automatic val_t pack(input logic neg, input logic ovf, input logic [2*W-1:0] m);
    logic [2*W-1:0] lim;
    logic [2*W-1:0] mm;
    logic [2*W-1:0] sm;
    begin
      lim = (2*W)'({1'b1, {(W-1){1'b0}}}) - (neg ? '0 : (2*W)'(1));
      mm = (ovf || m > lim) ? lim : m;
      sm = neg ? (~mm + (2*W)'(1)) : mm;
      pack = sm[W-1:0];
    end
  endfunction

  function automatic logic [W-1:0] mag(input val_t x);
    mag = x[W-1] ? (~x + W'(1)) : x;
  endfunction

  function automatic logic signed [OUT_BITS-1:0] sat32(input val_t x);
    logic signed [W+32:0] v;
    begin
      v = (W + 33)'(x);
      if (v > (W + 33)'(33'sh0_7FFF_FFFF)) sat32 = 32'sh7FFF_FFFF;
      else if (v < -(W + 33)'(33'sh0_8000_0000)) sat32 = 32'sh8000_0000;
      else sat32 = v[OUT_BITS-1:0];
    end
  endfunction

  // ALU add/sub with saturation
  logic signed [W:0] sum;
  always_comb begin
    sum = (uop.op == OP_SUB) ? ((W+1)'(opa) - (W+1)'(opb)) : ((W+1)'(opa) + (W+1)'(opb));
  end

  // Divider state: restoring, one bit per cycle
  logic [W-1:0] dvs;
  logic [2*W-1:0] dnum;
  logic [W:0] drem;
  logic [2*W-1:0] dq;
  logic [$clog2(DIVN+1)-1:0] dcnt;
  logic dneg;
  logic [W:0] drem_sh;
  logic [W:0] drem_nx;
  logic dbit;

  assign drem_sh = {drem[W-1:0], dnum[2*W-1]};
  assign dbit = drem_sh >= {1'b0, dvs};
  assign drem_nx = dbit ? drem_sh - {1'b0, dvs} : drem_sh;

  logic mul_ovf;
  logic [2*W-1:0] mul_sh;
  assign mul_sh = prod >> FRAC_BITS;
  assign mul_ovf = 1'b0;

  // Limiter gates: slope product (DQ2 left, T3 right) above threshold
  logic gate_l, gate_r;
  val_t thr_v;
  assign thr_v = W'(tiny);

  job_t job_h;
  assign job_h = job_q[job_head];
  assign job_rd = (bst == B_IDLE) && (job_cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      bst <= B_IDLE;
      pc <= '0;
      out_valid <= 1'b0;
      dcnt <= '0;
      gate_l <= 1'b0;
      gate_r <= 1'b0;
    end else begin
      unique case (bst)
        B_IDLE: begin
          if (job_rd) begin
            rf[R_QN] <= job_h.q_new; rf[R_Q0] <= job_h.q0; rf[R_Q1] <= job_h.q1;
            rf[R_Q2] <= job_h.q2; rf[R_S0] <= job_h.s0; rf[R_S1] <= job_h.s1;
            rf[R_S2] <= job_h.s2; rf[R_L0] <= job_h.l0; rf[R_L1] <= job_h.l1;
            rf[R_R0] <= job_h.r0; rf[R_R1] <= job_h.r1;
            rf[R_TWO] <= pack(1'b0, 1'b0, (2*W)'(2) << FRAC_BITS);
            pc <= '0;
            bst <= B_LOAD;
          end
        end
        B_LOAD: begin
          opa <= rf[uop.a];
          opb <= rf[uop.b];
          bst <= B_ISSUE;
        end
        B_ISSUE: begin
          unique case (uop.op)
            OP_ADD, OP_SUB: begin
              res <= pack(sum[W], 1'b0, sum[W] ? (2*W)'(-sum) : (2*W)'(sum));
              bst <= B_WB;
            end
            OP_MUL: begin
              prod <= (2*W)'(mag(opa)) * (2*W)'(mag(opb));
              pneg <= opa[W-1] ^ opb[W-1];
              bst <= B_MUL;
            end
            OP_DIV: begin
              // Numerator bits enter MSB first: the dividend, then FRAC_BITS zeros
              dnum <= (2*W)'(mag(opa)) << W;
              dvs <= mag(opb);
              drem <= '0;
              dq <= '0;
              dneg <= opa[W-1] ^ opb[W-1];
              dcnt <= '0;
              bst <= B_DIV;
            end
          endcase
        end
        B_MUL: begin
          res <= pack(pneg, mul_ovf, mul_sh);
          bst <= B_WB;
        end
        B_DIV: begin
          if (opa == '0) begin
            res <= '0;
            bst <= B_WB;
          end else if (dvs == '0) begin
            res <= pack(dneg, 1'b1, '0);
            bst <= B_WB;
          end else if (dcnt == DIVN[$bits(dcnt)-1:0]) begin
            res <= pack(dneg, 1'b0, dq);
            bst <= B_WB;
          end else begin
            drem <= drem_nx;
            dnum <= dnum << 1;
            dq <= {dq[2*W-2:0], dbit};
            dcnt <= dcnt + ($bits(dcnt))'(1);
          end
        end
        B_WB: begin
          // Gate corrections on the slope product; write zero for a gated correction
          if (uop.d == R_DQ2) gate_l <= res > thr_v;
          if (uop.d == R_T3) gate_r <= res > thr_v;
          if (uop.d == R_CL && !gate_l) rf[uop.d] <= '0;
          else if (uop.d == R_CR && !gate_r) rf[uop.d] <= '0;
          else rf[uop.d] <= res;
          if (pc == PC_LAST) bst <= B_OUT;
          else begin
            pc <= pc + PCW'(1);
            bst <= B_LOAD;
          end
        end
        B_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            left_state <= sat32(rf[R_OL]);
            right_state <= sat32(res);
            bst <= B_IDLE;
          end
        end
        default: bst <= B_IDLE;
      endcase
      if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_q_bound: assert property (@(posedge clk) disable iff (rst) job_cnt != 2'd3)
    else $error("queue count out of range");
  a_no_over: assert property (@(posedge clk) disable iff (rst) job_cnt == 2'd2 |-> !job_wr)
    else $error("queue overflow");
  a_rd_nonempty: assert property (@(posedge clk) disable iff (rst) job_rd |-> job_cnt != 2'd0)
    else $error("queue underflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_state))
    else $error("result dropped");
`endif

endmodule

// ----- src/plmvl_front.sv -----
// Front end: input window, line restart and face job issue
`timescale 1ns / 1ps
module plmvl_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  line_start,
  input  logic signed [plmvl_pkg::IN_BITS-1:0]  cell_value,
  input  logic [plmvl_pkg::POS_BITS-1:0]        center_spacing,
  input  logic [plmvl_pkg::POS_BITS-1:0]        half_left,
  input  logic [plmvl_pkg::POS_BITS-1:0]        half_right,
  output logic                                  job_valid,
  input  logic                                  job_ready,
  output logic [11*VALUE_BITS-1:0]              job_data
);

  logic signed [VALUE_BITS-1:0] qw [3];
  logic signed [VALUE_BITS-1:0] sw [3];
  logic signed [VALUE_BITS-1:0] lw [2];
  logic signed [VALUE_BITS-1:0] rw [2];
  logic [1:0] fill_count;
  logic signed [VALUE_BITS-1:0] qin, sp, hl, hr;
  logic [1:0] fill_eff;
  logic accept;

  // Clamp inputs to the working range
  function automatic logic signed [VALUE_BITS-1:0] clamp_in(input logic signed [32:0] x);
    logic signed [VALUE_BITS+32:0] w;
    logic signed [VALUE_BITS+32:0] hi;
    logic signed [VALUE_BITS+32:0] lo;
    begin
      w  = (VALUE_BITS + 33)'(x);
      hi = (VALUE_BITS + 33)'({1'b0, {(VALUE_BITS-1){1'b1}}});
      lo = -hi - 1;
      if (w > hi) clamp_in = hi[VALUE_BITS-1:0];
      else if (w < lo) clamp_in = lo[VALUE_BITS-1:0];
      else clamp_in = w[VALUE_BITS-1:0];
    end
  endfunction

  assign qin = clamp_in(33'(cell_value));
  assign sp  = clamp_in({2'b00, center_spacing});
  assign hl  = clamp_in({2'b00, half_left});
  assign hr  = clamp_in({2'b00, half_right});

  assign fill_eff = line_start ? 2'd0 : fill_count;
  // Hold the input while a due job cannot enter the queue
  assign in_ready  = (fill_eff != 2'd3) || job_ready;
  assign accept    = in_valid && in_ready;
  assign job_valid = in_valid && (fill_eff == 2'd3);
  assign job_data  = {qin, qw[0], qw[1], qw[2], sw[0], sw[1], sw[2],
                      lw[0], lw[1], rw[0], rw[1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      for (int i = 0; i < 3; i++) begin
        qw[i] <= '0;
        sw[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        lw[i] <= '0;
        rw[i] <= '0;
      end
    end else if (accept) begin
      qw[2] <= line_start ? '0 : qw[1];
      qw[1] <= line_start ? '0 : qw[0];
      qw[0] <= qin;
      sw[2] <= line_start ? '0 : sw[1];
      sw[1] <= line_start ? '0 : sw[0];
      sw[0] <= sp;
      lw[1] <= line_start ? '0 : lw[0];
      lw[0] <= hl;
      rw[1] <= line_start ? '0 : rw[0];
      rw[0] <= hr;
      fill_count <= (fill_eff == 2'd3) ? 2'd3 : fill_eff + 2'd1;
    end
  end

endmodule
